// ===== design/otpt_pkg.sv =====
// package: types, state codes and constants of the onset tempo and phase tracker
`default_nettype none

package otpt_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ONSET_LEVEL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ONSET_RISE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PERIOD_US = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PERIOD_US = 2'd3;

   localparam logic [15:0] ONSET_LEVEL_RESET = 16'd8192;
   localparam logic [15:0] ONSET_RISE_RESET  = 16'd1024;
   localparam logic [19:0] MIN_PERIOD_RESET  = 20'd250000;
   localparam logic [19:0] MAX_PERIOD_RESET  = 20'd1000000;
   localparam logic [19:0] PERIOD_RESET      = 20'd500000;

   localparam logic [20:0] SINCE_MAX    = 21'h1FFFFF;
   // ceil(2^37 / 15625), with 8000000 = 512 * 15625
   localparam logic [23:0] DECAY_RECIP  = 24'd8796094;
   localparam logic [15:0] GAIN_BASE    = 16'd9830;
   localparam logic [20:0] GAIN_SPAN    = 21'd22938;
   localparam logic [31:0] ROUND_HALF   = 32'd32768;
   localparam logic [16:0] ONE_Q16      = 17'h10000;
   localparam logic [15:0] HALF_PHASE   = 16'd32768;
   localparam logic [5:0]  DIV_FULL_CNT = 6'd32;
   localparam logic [5:0]  DIV_FRAC_CNT = 6'd16;

   typedef struct packed {
      logic [15:0] bass_level;
      logic [15:0] elapsed_us;
   } req_payload_type;

   typedef struct packed {
      logic        onset;
      logic [15:0] beat_phase;
      logic [19:0] period_us;
      logic [15:0] confidence;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PDIV,
      ST_PHASE,
      ST_DMUL,
      ST_DSUB,
      ST_RLOAD,
      ST_RDIV,
      ST_MATCH,
      ST_GAIN,
      ST_GSUM,
      ST_STEP,
      ST_UPD,
      ST_PULL,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== design/otpt_ifs.sv =====
// interfaces: request and response channels of the tracker
`default_nettype none

interface otpt_req_if;
   logic                     valid;
   logic                     ready;
   otpt_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface otpt_rsp_if;
   logic                     valid;
   logic                     ready;
   otpt_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/onset_tempo_phase_tracker_unit.sv =====
// top level: onset detection, tempo and phase tracking on one shared divider and multiplier
//
//  channel   dir  handshake            payload
//  req_if    in   valid/ready          bass_level[15:0], elapsed_us[15:0]
//  rsp_if    out  valid/ready          onset, beat_phase[15:0], period_us[19:0], confidence[15:0]
//  csr_*     in   csr_wr_en, no wait   csr_index[1:0], csr_wdata[19:0]
//
//  a transaction runs PDIV, PHASE, DMUL, DSUB, OUT without onset; PDIV, PHASE, RLOAD, RDIV,
//  MATCH, GAIN, GSUM, STEP, UPD, PULL, OUT with an onset in range, without RDIV and MATCH when
//  the match is zero, and PDIV, PHASE, PULL, OUT out of range; the next request is taken the
//  cycle after the result load; the restoring divider gives one quotient bit per cycle,
//  32 bits for the phase step, 16 bits for the match ratio; the decay is a reciprocal multiply
//  synchronous reset returns state, CSRs and tracker registers to defaults, not the datapath
//  a finished result waits in the output register; the next request is taken meanwhile
`default_nettype none

module onset_tempo_phase_tracker_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   otpt_req_if.sink                            req_if,
   otpt_rsp_if.source                          rsp_if,
   input  wire                                 csr_wr_en,
   input  wire [otpt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [otpt_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import otpt_pkg::*;

   state_type state_ff, state_in;

   logic [15:0] onset_level_ff, onset_rise_ff;
   logic [19:0] min_period_ff, max_period_ff;

   logic [19:0] period_ff, period_in;
   logic [15:0] phase_ff, phase_in;
   logic [15:0] conf_ff, conf_in;
   logic [20:0] since_ff, since_in;
   logic [15:0] prev_ff, prev_in;

   logic [15:0] level_ff, level_in;
   logic [15:0] dt_ff, dt_in;
   logic        onset_ff, onset_in;
   logic [20:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [16:0] match_ff, match_in;
   logic [15:0] gain_ff, gain_in;
   logic [47:0] prod_ff, prod_in;

   // shared restoring divider
   logic [22:0] div_rem_ff, div_rem_in;
   logic [31:0] div_dvd_ff, div_dvd_in;
   logic [22:0] div_dvs_ff, div_dvs_in;
   logic [15:0] div_quo_ff, div_quo_in;
   logic [5:0]  div_cnt_ff, div_cnt_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [19:0] per;
   logic [21:0] since_sum;
   logic [16:0] level_diff;
   logic        onset_now;
   logic        div_busy;
   logic        div_last;
   logic [23:0] div_trial;
   logic [23:0] div_diff;
   logic        div_ge;
   logic [23:0] mul_a;
   logic [23:0] mul_b;
   logic [47:0] mul_prod;
   logic [15:0] decay;
   logic        req_take;
   logic        rsp_load;

   assign per        = (period_ff == '0) ? 20'd1 : period_ff;
   assign since_sum  = {1'b0, since_ff} + {6'b0, req_if.payload.elapsed_us};
   assign level_diff = {1'b0, level_ff} - {1'b0, prev_ff};
   assign onset_now  = (level_ff > onset_level_ff) && (level_ff > prev_ff) &&
                       (level_diff[15:0] > onset_rise_ff) &&
                       (since_ff > {1'b0, min_period_ff});

   assign div_busy  = (state_ff == ST_PDIV) || (state_ff == ST_RDIV);
   assign div_last  = div_cnt_ff == 6'd1;
   assign div_trial = {div_rem_ff, div_dvd_ff[31]};
   assign div_diff  = div_trial - {1'b0, div_dvs_ff};
   assign div_ge    = div_trial >= {1'b0, div_dvs_ff};

   assign mul_prod = {24'b0, mul_a} * {24'b0, mul_b};
   // conf*dt/8000000 as ((x >> 9) * DECAY_RECIP) >> 37, exact for x below 2^32
   assign decay    = {6'b0, prod_ff[46:37]};

   assign req_take = (state_ff == ST_IDLE) && req_if.valid;
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_if.ready);

   assign req_if.ready   = state_ff == ST_IDLE;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_take) state_in = ST_PDIV;
         ST_PDIV:  if (div_last) state_in = ST_PHASE;
         ST_PHASE: begin
            if (!onset_now) state_in = ST_DMUL;
            else if (since_ff <= {1'b0, max_period_ff}) state_in = ST_RLOAD;
            else state_in = ST_PULL;
         end
         ST_DMUL:  state_in = ST_DSUB;
         ST_DSUB:  state_in = ST_OUT;
         ST_RLOAD: state_in = ({1'b0, per} <= mag_ff) ? ST_GAIN : ST_RDIV;
         ST_RDIV:  if (div_last) state_in = ST_MATCH;
         ST_MATCH: state_in = ST_GAIN;
         ST_GAIN:  state_in = ST_GSUM;
         ST_GSUM:  state_in = ST_STEP;
         ST_STEP:  state_in = ST_UPD;
         ST_UPD:   state_in = ST_PULL;
         ST_PULL:  state_in = ST_OUT;
         ST_OUT:   if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // multiplier operand select
   always_comb begin
      case (state_ff)
         ST_PHASE: begin
            mul_a = {8'b0, conf_ff};
            mul_b = {8'b0, dt_ff};
         end
         ST_DMUL: begin
            mul_a = {1'b0, prod_ff[31:9]};
            mul_b = DECAY_RECIP;
         end
         ST_GAIN: begin
            mul_a = {3'b0, GAIN_SPAN};
            mul_b = {7'b0, match_ff};
         end
         default: begin
            mul_a = {3'b0, mag_ff};
            mul_b = {8'b0, gain_ff};
         end
      endcase
   end

   // datapath
   always_comb begin
      logic signed [22:0] p_sum;
      logic signed [22:0] p_min;
      logic signed [22:0] p_max;
      logic [20:0]        step;
      logic [31:0]        gain_sum;
      logic [18:0]        conf_sum;
      logic [16:0]        phase_gap;

      level_in     = level_ff;
      dt_in        = dt_ff;
      prev_in      = prev_ff;
      since_in     = since_ff;
      phase_in     = phase_ff;
      period_in    = period_ff;
      conf_in      = conf_ff;
      onset_in     = onset_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      match_in     = match_ff;
      gain_in      = gain_ff;
      prod_in      = prod_ff;
      div_rem_in   = div_rem_ff;
      div_dvd_in   = div_dvd_ff;
      div_dvs_in   = div_dvs_ff;
      div_quo_in   = div_quo_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      step      = prod_ff[36:16];
      p_sum     = neg_ff ? ($signed({3'b0, per}) - $signed({2'b0, step}))
                         : ($signed({3'b0, per}) + $signed({2'b0, step}));
      p_min     = $signed({3'b0, min_period_ff});
      p_max     = $signed({3'b0, max_period_ff});
      gain_sum  = prod_ff[31:0] + ROUND_HALF;
      conf_sum  = {3'b0, conf_ff} + {2'b0, conf_ff, 1'b0} + {2'b0, match_ff};
      phase_gap = ONE_Q16 - {1'b0, phase_ff};

      if (div_busy) begin
         div_rem_in = div_ge ? div_diff[22:0] : div_trial[22:0];
         div_dvd_in = {div_dvd_ff[30:0], 1'b0};
         div_quo_in = {div_quo_ff[14:0], div_ge};
         div_cnt_in = div_cnt_ff - 6'd1;
      end

      if (rsp_valid_ff && rsp_if.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               level_in   = req_if.payload.bass_level;
               dt_in      = req_if.payload.elapsed_us;
               since_in   = since_sum[21] ? SINCE_MAX : since_sum[20:0];
               div_rem_in = '0;
               div_dvd_in = {req_if.payload.elapsed_us, 16'b0};
               div_dvs_in = {3'b0, per};
               div_quo_in = '0;
               div_cnt_in = DIV_FULL_CNT;
            end
         end
         ST_PHASE: begin
            phase_in = phase_ff + div_quo_ff;
            onset_in = onset_now;
            prev_in  = level_ff;
            prod_in  = mul_prod;
            neg_in   = since_ff < {1'b0, per};
            mag_in   = (since_ff < {1'b0, per}) ? ({1'b0, per} - since_ff)
                                                : (since_ff - {1'b0, per});
            if (onset_now) since_in = '0;
         end
         ST_DMUL: begin
            prod_in = mul_prod;
         end
         ST_DSUB: begin
            conf_in = conf_ff - decay;
         end
         ST_RLOAD: begin
            match_in   = '0;
            div_rem_in = {2'b0, mag_ff};
            div_dvd_in = '0;
            div_dvs_in = {3'b0, per};
            div_quo_in = '0;
            div_cnt_in = DIV_FRAC_CNT;
         end
         ST_MATCH: begin
            match_in = ONE_Q16 - {1'b0, div_quo_ff};
         end
         ST_GAIN: begin
            prod_in = mul_prod;
         end
         ST_GSUM: begin
            gain_in = GAIN_BASE + gain_sum[31:16];
         end
         ST_STEP: begin
            prod_in = mul_prod;
         end
         ST_UPD: begin
            if (p_sum < p_min) p_sum = p_min;
            if (p_sum > p_max) p_sum = p_max;
            if (p_sum < 23'sd1) p_sum = 23'sd1;
            period_in = p_sum[19:0];
            conf_in   = conf_sum[17:2];
         end
         ST_PULL: begin
            if (phase_ff <= HALF_PHASE) phase_in = {1'b0, phase_ff[15:1]};
            else phase_in = phase_ff + phase_gap[16:1];
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.onset      = onset_ff;
               rsp_data_in.beat_phase = phase_ff;
               rsp_data_in.period_us  = period_ff;
               rsp_data_in.confidence = conf_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         onset_level_ff <= ONSET_LEVEL_RESET;
         onset_rise_ff  <= ONSET_RISE_RESET;
         min_period_ff  <= MIN_PERIOD_RESET;
         max_period_ff  <= MAX_PERIOD_RESET;
         period_ff      <= PERIOD_RESET;
         phase_ff       <= '0;
         conf_ff        <= '0;
         since_ff       <= '0;
         prev_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
         phase_ff     <= phase_in;
         conf_ff      <= conf_in;
         since_ff     <= since_in;
         prev_ff      <= prev_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ONSET_LEVEL:   onset_level_ff <= csr_wdata[15:0];
               CSR_ONSET_RISE:    onset_rise_ff  <= csr_wdata[15:0];
               CSR_MIN_PERIOD_US: min_period_ff  <= csr_wdata;
               CSR_MAX_PERIOD_US: max_period_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      level_ff    <= level_in;
      dt_ff       <= dt_in;
      onset_ff    <= onset_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      match_ff    <= match_in;
      gain_ff     <= gain_in;
      prod_ff     <= prod_in;
      div_rem_ff  <= div_rem_in;
      div_dvd_ff  <= div_dvd_in;
      div_dvs_ff  <= div_dvs_in;
      div_quo_ff  <= div_quo_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // the divider never runs with an exhausted count
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> div_cnt_ff != 6'd0)
      else $error("divider running with zero count");

   // tracked period stays nonzero
   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      period_ff != 20'd0)
      else $error("beat period became zero");

   // decay never exceeds the confidence it is taken from
   a_decay_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DSUB) |-> decay <= conf_ff)
      else $error("confidence decay larger than confidence");

   // a waiting result is not overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_if.ready) |=>
         (state_ff == ST_OUT && $stable(rsp_data_ff)))
      else $error("pending result overwritten");

endmodule

`default_nettype wire
